@@ hw/rtl/i2cbm_pkg.sv @@
package i2cbm_pkg;

    localparam int COUNTER_WIDTH_DEFAULT = 16;
    localparam int CFG_WIDTH             = 16;
    localparam int BYTE_WIDTH            = 8;
    localparam int CMD_WIDTH             = 3;
    localparam int BIT_IDX_WIDTH         = 3;

    localparam logic [CFG_WIDTH-1:0]     HALF_PERIOD_RESET = 16'd9;
    localparam logic [BIT_IDX_WIDTH-1:0] BIT_LAST          = 3'd7;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START_HI = 4'd1,
        PH_START_LO = 4'd2,
        PH_STOP_LO  = 4'd3,
        PH_STOP_HI  = 4'd4,
        PH_BIT_LOW  = 4'd5,
        PH_BIT_HIGH = 4'd6,
        PH_ACK_LOW  = 4'd7,
        PH_ACK_HIGH = 4'd8
    } t_phase;

    typedef struct packed {
        logic scl;
        logic sda;
        logic oe;
    } t_lines;

    // Line levels driven on entry to a phase.
    function automatic t_lines f_lines(t_phase ph, logic is_write, logic data_bit);
        t_lines l;
        l = '{scl: 1'b1, sda: 1'b1, oe: 1'b1};
        unique case (ph)
            PH_START_HI: l = '{scl: 1'b1, sda: 1'b1, oe: 1'b1};
            PH_START_LO: l = '{scl: 1'b1, sda: 1'b0, oe: 1'b1};
            PH_STOP_LO:  l = '{scl: 1'b1, sda: 1'b0, oe: 1'b1};
            PH_STOP_HI:  l = '{scl: 1'b1, sda: 1'b1, oe: 1'b1};
            PH_BIT_LOW:  l = is_write ? t_lines'{scl: 1'b0, sda: data_bit, oe: 1'b1}
                                      : t_lines'{scl: 1'b0, sda: 1'b1, oe: 1'b0};
            PH_BIT_HIGH: l = is_write ? t_lines'{scl: 1'b1, sda: data_bit, oe: 1'b1}
                                      : t_lines'{scl: 1'b1, sda: 1'b1, oe: 1'b0};
            PH_ACK_LOW:  l = is_write ? t_lines'{scl: 1'b0, sda: 1'b1, oe: 1'b0}
                                      : t_lines'{scl: 1'b0, sda: 1'b1, oe: 1'b1};
            PH_ACK_HIGH: l = is_write ? t_lines'{scl: 1'b1, sda: 1'b1, oe: 1'b0}
                                      : t_lines'{scl: 1'b1, sda: 1'b1, oe: 1'b1};
            default:     l = '{scl: 1'b1, sda: 1'b1, oe: 1'b1};
        endcase
        return l;
    endfunction

endpackage

@@ hw/rtl/i2cbm_if.sv @@
interface i2cbm_in_if;
    logic                                valid;
    logic                                ready;
    logic [i2cbm_pkg::CMD_WIDTH-1:0]     command;
    logic [i2cbm_pkg::BYTE_WIDTH-1:0]    write_byte;
    logic                                sda_in;

    modport source (output valid, command, write_byte, sda_in, input ready);
    modport sink   (input valid, command, write_byte, sda_in, output ready);
endinterface

interface i2cbm_out_if;
    logic                                valid;
    logic                                ready;
    logic                                scl_level;
    logic                                sda_value;
    logic                                sda_enable;
    logic                                busy_res;
    logic                                done_res;
    logic [i2cbm_pkg::BYTE_WIDTH-1:0]    read_byte;

    modport source (output valid, scl_level, sda_value, sda_enable, busy_res, done_res,
                    read_byte, input ready);
    modport sink   (input valid, scl_level, sda_value, sda_enable, busy_res, done_res,
                    read_byte, output ready);
endinterface

@@ hw/rtl/i2c_bit_master.sv @@
// I2C master line sequencer. Every transaction on i_in is one tick of line time: it may carry
// a command (start, stop, write byte, read byte) and always carries the sampled SDA level.
// Every accepted tick yields exactly one transaction on o_out with the SCL level, SDA value,
// SDA output enable, busy, a one-tick done pulse and the byte from the last completed read.
// Each SCL low or high phase lasts i_cfg_wdata ticks as last written (zero counts as one,
// values above the tick counter range saturate; reset value 9). A command that arrives while
// busy, or an unknown command code, is ignored. A write sends 8 bits MSB first and then an
// ACK slot with SDA released (the ACK is not checked); a read samples SDA on the last tick of
// each high phase and ends with a NACK. Rate: one tick per clock cycle. The whole update for
// a tick is a single pass from the state registers into the result register, and the input
// stays ready while the result register is empty or being taken in the same cycle, so the
// only thing that slows the block is backpressure on o_out. Write the configuration only
// while the block is idle.
module i2c_bit_master #(
    parameter int COUNTER_WIDTH = i2cbm_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [i2cbm_pkg::CFG_WIDTH-1:0]    i_cfg_wdata,
    i2cbm_in_if.sink                           i_in,
    i2cbm_out_if.source                        o_out
);

    // Comparison width covers both the counter and the config field.
    localparam int LW = (COUNTER_WIDTH > i2cbm_pkg::CFG_WIDTH) ? COUNTER_WIDTH
                                                                : i2cbm_pkg::CFG_WIDTH;
    localparam logic [LW-1:0] CNT_MAX = LW'({COUNTER_WIDTH{1'b1}});

    // State
    logic [i2cbm_pkg::CFG_WIDTH-1:0]     r_half_period;
    i2cbm_pkg::t_phase                   r_phase, n_phase;
    i2cbm_pkg::t_cmd                     r_op, n_op;
    logic [i2cbm_pkg::BIT_IDX_WIDTH-1:0] r_bit_idx, n_bit_idx;
    logic [COUNTER_WIDTH-1:0]            r_tick, n_tick;
    logic [i2cbm_pkg::BYTE_WIDTH-1:0]    r_shift, n_shift;
    logic [i2cbm_pkg::BYTE_WIDTH-1:0]    r_rx, n_rx;
    logic                                r_scl, n_scl;
    logic                                r_sda, n_sda;
    logic                                r_sda_oe, n_sda_oe;

    // Result register
    logic                                r_out_valid;
    logic                                r_out_scl;
    logic                                r_out_sda;
    logic                                r_out_oe;
    logic                                r_out_busy;
    logic                                r_out_done;
    logic [i2cbm_pkg::BYTE_WIDTH-1:0]    r_out_rx;

    logic                                w_accept;
    logic                                w_enter;
    logic                                w_ack_end;
    logic                                w_done;
    logic [COUNTER_WIDTH-1:0]            w_tick_inc;
    logic [LW-1:0]                       w_cfg_ext;
    logic [LW-1:0]                       w_len;
    logic                                w_expire;
    i2cbm_pkg::t_lines                   w_lines;

    // Input is taken whenever the result register can be loaded this cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // Phase length: zero means one, saturate to the counter range.
    assign w_cfg_ext  = LW'(r_half_period);
    always_comb begin
        if (w_cfg_ext == '0) begin
            w_len = LW'(1);
        end else if (w_cfg_ext > CNT_MAX) begin
            w_len = CNT_MAX;
        end else begin
            w_len = w_cfg_ext;
        end
    end

    assign w_tick_inc = r_tick + COUNTER_WIDTH'(1);
    assign w_expire   = LW'(w_tick_inc) >= w_len;

    // Next state
    always_comb begin
        n_phase   = r_phase;
        n_op      = r_op;
        n_bit_idx = r_bit_idx;
        n_tick    = r_tick;
        n_shift   = r_shift;
        n_rx      = r_rx;
        w_enter   = 1'b0;
        w_ack_end = 1'b0;
        w_done    = 1'b0;
        if (r_phase == i2cbm_pkg::PH_IDLE) begin
            unique case (i2cbm_pkg::t_cmd'(i_in.command))
                i2cbm_pkg::CMD_START: begin
                    n_op      = i2cbm_pkg::CMD_START;
                    n_bit_idx = '0;
                    n_tick    = '0;
                    n_phase   = i2cbm_pkg::PH_START_HI;
                    w_enter   = 1'b1;
                end
                i2cbm_pkg::CMD_STOP: begin
                    n_op      = i2cbm_pkg::CMD_STOP;
                    n_bit_idx = '0;
                    n_tick    = '0;
                    n_phase   = i2cbm_pkg::PH_STOP_LO;
                    w_enter   = 1'b1;
                end
                i2cbm_pkg::CMD_WRITE: begin
                    n_op      = i2cbm_pkg::CMD_WRITE;
                    n_bit_idx = '0;
                    n_tick    = '0;
                    n_shift   = i_in.write_byte;
                    n_phase   = i2cbm_pkg::PH_BIT_LOW;
                    w_enter   = 1'b1;
                end
                i2cbm_pkg::CMD_READ: begin
                    n_op      = i2cbm_pkg::CMD_READ;
                    n_bit_idx = '0;
                    n_tick    = '0;
                    n_shift   = '0;
                    n_phase   = i2cbm_pkg::PH_BIT_LOW;
                    w_enter   = 1'b1;
                end
                default: ;  // no command, or an unknown code
            endcase
        end else begin
            n_tick = w_tick_inc;
            if (w_expire) begin
                n_tick = '0;
                unique case (r_phase)
                    i2cbm_pkg::PH_START_HI: begin
                        n_phase = i2cbm_pkg::PH_START_LO;
                        w_enter = 1'b1;
                    end
                    i2cbm_pkg::PH_STOP_LO: begin
                        n_phase = i2cbm_pkg::PH_STOP_HI;
                        w_enter = 1'b1;
                    end
                    i2cbm_pkg::PH_START_LO,
                    i2cbm_pkg::PH_STOP_HI: begin
                        n_phase = i2cbm_pkg::PH_IDLE;
                        w_done  = 1'b1;
                    end
                    i2cbm_pkg::PH_BIT_LOW: begin
                        n_phase = i2cbm_pkg::PH_BIT_HIGH;
                        w_enter = 1'b1;
                    end
                    i2cbm_pkg::PH_BIT_HIGH: begin
                        if (r_op == i2cbm_pkg::CMD_READ) begin
                            n_shift = {r_shift[i2cbm_pkg::BYTE_WIDTH-2:0], i_in.sda_in};
                        end
                        if (r_bit_idx == i2cbm_pkg::BIT_LAST) begin
                            n_phase = i2cbm_pkg::PH_ACK_LOW;
                        end else begin
                            n_bit_idx = r_bit_idx + i2cbm_pkg::BIT_IDX_WIDTH'(1);
                            n_phase   = i2cbm_pkg::PH_BIT_LOW;
                        end
                        w_enter = 1'b1;
                    end
                    i2cbm_pkg::PH_ACK_LOW: begin
                        n_phase = i2cbm_pkg::PH_ACK_HIGH;
                        w_enter = 1'b1;
                    end
                    i2cbm_pkg::PH_ACK_HIGH: begin
                        if (r_op == i2cbm_pkg::CMD_READ) begin
                            n_rx = r_shift;
                        end
                        n_phase   = i2cbm_pkg::PH_IDLE;
                        w_ack_end = 1'b1;
                        w_done    = 1'b1;
                    end
                    default: begin
                        n_phase = i2cbm_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Line outputs: set on phase entry, SCL dropped after the ACK/NACK slot.
    assign w_lines = i2cbm_pkg::f_lines(n_phase, n_op == i2cbm_pkg::CMD_WRITE,
                                        n_shift[~n_bit_idx]);
    always_comb begin
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_sda_oe = r_sda_oe;
        if (w_enter) begin
            n_scl    = w_lines.scl;
            n_sda    = w_lines.sda;
            n_sda_oe = w_lines.oe;
        end else if (w_ack_end) begin
            n_scl    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= i2cbm_pkg::HALF_PERIOD_RESET;
            r_phase       <= i2cbm_pkg::PH_IDLE;
            r_op          <= i2cbm_pkg::CMD_NONE;
            r_bit_idx     <= '0;
            r_tick        <= '0;
            r_shift       <= '0;
            r_rx          <= '0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_sda_oe      <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_half_period <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_phase     <= n_phase;
                r_op        <= n_op;
                r_bit_idx   <= n_bit_idx;
                r_tick      <= n_tick;
                r_shift     <= n_shift;
                r_rx        <= n_rx;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_sda_oe    <= n_sda_oe;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each accepted tick.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_scl  <= n_scl;
            r_out_sda  <= n_sda;
            r_out_oe   <= n_sda_oe;
            r_out_busy <= (n_phase != i2cbm_pkg::PH_IDLE);
            r_out_done <= w_done;
            r_out_rx   <= n_rx;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.scl_level  = r_out_scl;
    assign o_out.sda_value  = r_out_sda;
    assign o_out.sda_enable = r_out_oe;
    assign o_out.busy_res   = r_out_busy;
    assign o_out.done_res   = r_out_done;
    assign o_out.read_byte  = r_out_rx;

    // Checks
    a_idle_tick_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == i2cbm_pkg::PH_IDLE) |-> (r_tick == '0))
        else $error("tick counter running while idle");

    a_accept_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted tick produced no result");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> !r_out_busy)
        else $error("done reported while still busy");

    a_write_drives_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == i2cbm_pkg::PH_BIT_LOW || r_phase == i2cbm_pkg::PH_BIT_HIGH)
         && r_op == i2cbm_pkg::CMD_WRITE) |-> r_sda_oe)
        else $error("SDA released during a write data bit");

    a_busy_holds_cfg_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != i2cbm_pkg::PH_IDLE && !w_accept) |=> $stable(r_phase))
        else $error("phase moved without a tick");

endmodule
